FILE: hw/rtl/adcpwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcpwr_pkg
// Shared widths, opcodes and types for the ADC-to-power table lookup.
// ----------------------------------------------------------------------------
package adcpwr_pkg;

    localparam int ADC_W   = 16;   // ADC count / table entry width
    localparam int IDX_W   = 5;    // entry_index and table_position width
    localparam int BASE_W  = 8;    // base_power register width
    localparam int POWER_W = 9;    // power_level width

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    localparam logic signed [BASE_W-1:0] BASE_RESET = -8'sd31;

    typedef logic [ADC_W-1:0] t_adc;

    // compare unit verdict for one table pair
    typedef struct packed {
        logic hit;     // pair brackets the count (or first-pair rule applies)
        logic upper;   // count lies above the floored midpoint
    } t_cmp_res;

endpackage

FILE: hw/rtl/adcpwr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcpwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adcpwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/adcpwr_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcpwr_cmp
// Pair compare unit: bracket test and floored-midpoint split for one pair.
// ----------------------------------------------------------------------------
module adcpwr_cmp
    import adcpwr_pkg::*;
(
    input  t_adc     i_x,
    input  t_adc     i_lo,
    input  t_adc     i_hi,
    input  logic     i_first,   // pair (0,1): only the upper bound matters
    output t_cmp_res o_res
);

    logic [ADC_W:0] sum;
    t_adc           mid;

    assign sum = {1'b0, i_lo} + {1'b0, i_hi};
    assign mid = sum[ADC_W:1];

    always_comb begin
        o_res.hit   = (i_x <= i_hi) && (i_first || (i_x >= i_lo));
        o_res.upper = (i_x > mid);
    end

endmodule

FILE: hw/rtl/adc_to_power_table_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_power_table_lookup_core
// Converts a raw ADC count to a power level through a calibration table.
// ----------------------------------------------------------------------------
// The block keeps TABLE_ENTRIES rising ADC counts in a single-port-read RAM.
// A write transaction (op 0) stores one entry at acceptance and returns nothing;
// indexes at or beyond TABLE_ENTRIES are dropped. A convert transaction (op 1)
// scans adjacent pairs from the start, one RAM read per cycle through a single
// shared compare unit, and returns one result transaction: base_power plus the
// chosen position, the position, and a found flag. A count at or below entry 1
// maps to position 0. A conversion holds the input side through the fetch of
// entry 0, one compare per pair examined and the result handoff. A finished
// result sits in an output register, so the next transaction is taken while
// it waits. The user must write base_power through i_cfg_we / i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Table entries are undefined until written; converting against unwritten
// entries gives undefined results.
// ----------------------------------------------------------------------------
module adc_to_power_table_lookup_core
    import adcpwr_pkg::*;
#(
    parameter int TABLE_ENTRIES = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic        [BASE_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_op,
    input  logic        [IDX_W-1:0]   i_entry_index,
    input  logic        [ADC_W-1:0]   i_entry_value,
    input  logic        [ADC_W-1:0]   i_adc_value,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [POWER_W-1:0] o_power_level,
    output logic        [IDX_W-1:0]   o_table_position,
    output logic                      o_found
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 2);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;   // entry 0 arrives, request entry 1
    localparam logic [1:0] S_CHECK = 2'd2;   // compare pair (idx, idx+1)
    localparam logic [1:0] S_DONE  = 2'd3;   // result ready for output register

    logic [1:0]                r_state, n_state;
    logic [AW-1:0]             r_idx, n_idx;
    t_adc                      r_x, n_x;
    t_adc                      r_lo, n_lo;
    logic [AW-1:0]             r_pos, n_pos;
    logic                      r_found, n_found;
    logic signed [BASE_W-1:0]  r_base_power;

    logic                      r_out_valid;
    logic signed [POWER_W-1:0] r_power_level;
    logic [IDX_W-1:0]          r_table_position;
    logic                      r_out_found;

    logic                      in_xact;
    logic                      out_free;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    t_adc                      ram_rdata;
    t_cmp_res                  cmp;
    logic [AW+IDX_W-1:0]       idx_ext;
    logic [AW+IDX_W-1:0]       pos_ext;
    logic [AW+POWER_W-1:0]     pos_pw;
    logic [POWER_W-1:0]        power_sum;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xact    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // table writes land directly at acceptance
    assign idx_ext   = {{AW{1'b0}}, i_entry_index};
    assign ram_waddr = idx_ext[AW-1:0];
    assign ram_we    = in_xact && (i_op == OP_WRITE) &&
                       (32'(i_entry_index) < TABLE_ENTRIES);

    // read address: entry 0 on accept, entry 1 while fetching, next hi in scan
    always_comb begin
        case (r_state)
            S_FETCH: ram_raddr = AW'(1);
            S_CHECK: ram_raddr = r_idx + AW'(2);
            default: ram_raddr = '0;
        endcase
    end

    adcpwr_ram #(
        .WIDTH (ADC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    adcpwr_cmp u_cmp (
        .i_x     (r_x),
        .i_lo    (r_lo),
        .i_hi    (ram_rdata),
        .i_first (r_idx == '0),
        .o_res   (cmp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_x     = r_x;
        n_lo    = r_lo;
        n_pos   = r_pos;
        n_found = r_found;
        case (r_state)
            S_IDLE: begin
                if (in_xact && (i_op == OP_CONVERT)) begin
                    n_x     = i_adc_value;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_lo    = ram_rdata;
                n_idx   = '0;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (cmp.hit) begin
                    n_found = 1'b1;
                    if ((r_idx != '0) && cmp.upper) begin
                        n_pos = r_idx + AW'(1);
                    end else begin
                        n_pos = r_idx;
                    end
                    n_state = S_DONE;
                end else if (r_idx == LastIdx) begin
                    // no pair brackets the count
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_DONE;
                end else begin
                    n_lo  = ram_rdata;
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx   <= n_idx;
        r_x     <= n_x;
        r_lo    <= n_lo;
        r_pos   <= n_pos;
        r_found <= n_found;
    end

    // base_power register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_power <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_base_power <= i_cfg_wdata;
        end
    end

    // result formatting: both fields wrap to their port widths
    assign pos_ext   = {{IDX_W{1'b0}}, r_pos};
    assign pos_pw    = {{POWER_W{1'b0}}, r_pos};
    assign power_sum = {{(POWER_W-BASE_W){r_base_power[BASE_W-1]}}, r_base_power}
                       + pos_pw[POWER_W-1:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= (r_state == S_DONE);
        end
        if (out_free && (r_state == S_DONE)) begin
            r_power_level    <= power_sum;
            r_table_position <= pos_ext[IDX_W-1:0];
            r_out_found      <= r_found;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_power_level    = r_power_level;
    assign o_table_position = r_table_position;
    assign o_found          = r_out_found;

`ifndef ASSERT_OFF
    // table is only written while the sequencer is idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("table write outside idle");

    // scan index never runs past the last pair
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_idx <= LastIdx))
        else $error("scan index beyond last pair");

    // a miss always reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_table_position == '0))
        else $error("miss with nonzero position");

    // a new result only follows a finished scan
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result without completed scan");
`endif

endmodule

FILE: tb/tb_adc_to_power_table_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_to_power_table_lookup_core
// Self-checking bench for the ADC-to-power calibration table lookup.
// ----------------------------------------------------------------------------
// A local mirror of the table and of base_power predicts each conversion
// result when the transaction is accepted. Results are checked in order
// against that prediction. A directed part loads a ramp table and probes the
// first-pair rule, midpoint ties, the carry of the midpoint sum, dropped
// out-of-range writes, the no-bracket case and both base_power extremes. The
// random part runs phases with a fresh base_power and a fresh table (wide,
// dense, scrambled or dented), then conversions aimed at entries and
// midpoints mixed with live table rewrites. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_adc_to_power_table_lookup_core;
    import adcpwr_pkg::*;

    localparam int N_ENTRIES     = 31;
    localparam int SETTLE_CYCLES = N_ENTRIES + 8;   // worst conversion plus margin
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 125;

    typedef struct packed {
        logic signed [POWER_W-1:0] power;
        logic        [IDX_W-1:0]   pos;
        logic                      found;
    } lookup_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic        [BASE_W-1:0]  cfg_wdata;
    logic                      in_valid;
    logic                      o_in_stall;
    logic                      in_op;
    logic        [IDX_W-1:0]   in_entry_index;
    t_adc                      in_entry_value;
    t_adc                      in_adc_value;
    logic                      o_out_valid;
    logic                      out_stall;
    logic signed [POWER_W-1:0] o_power_level;
    logic        [IDX_W-1:0]   o_table_position;
    logic                      o_found;

    // mirror of the block state
    t_adc                      cal_mirror [N_ENTRIES];
    logic signed [BASE_W-1:0]  base_mirror;
    lookup_result_t            expected_lookups [$];

    int n_errors    = 0;
    int stall_hold  = 0;
    bit quiet_phase = 1'b0;   // no idling on either side while set

    adc_to_power_table_lookup_core #(
        .TABLE_ENTRIES (N_ENTRIES)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (in_op),
        .i_entry_index    (in_entry_index),
        .i_entry_value    (in_entry_value),
        .i_adc_value      (in_adc_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_power_level    (o_power_level),
        .o_table_position (o_table_position),
        .o_found          (o_found)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic lookup_result_t predict_lookup(t_adc count);
        lookup_result_t r;
        int pos;
        int lo;
        int hi;
        bit hit;
        pos = 0;
        hit = 1'b0;
        if (count <= cal_mirror[1]) begin
            hit = 1'b1;
        end else begin
            // first pair that brackets the count wins
            for (int i = 0; i + 1 < N_ENTRIES; i++) begin
                lo = cal_mirror[i];
                hi = cal_mirror[i+1];
                if (!hit && count >= lo && count <= hi) begin
                    hit = 1'b1;
                    pos = (count <= ((lo + hi) >> 1)) ? i : i + 1;
                end
            end
        end
        r.power = POWER_W'(int'(base_mirror) + pos);
        r.pos   = IDX_W'(pos);
        r.found = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic int pick_burst();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) < 65)
            return 0;
        return pick_burst();
    endfunction

    function automatic logic signed [BASE_W-1:0] pick_base();
        case ($urandom_range(4))
            0:       return -8'sd128;
            1:       return 8'sd127;
            2:       return 8'sd0;
            3:       return -8'sd1;
            default: return BASE_W'($urandom);
        endcase
    endfunction

    // counts aimed at entries, neighbors and midpoints of a random pair
    function automatic t_adc pick_count();
        int j;
        int mid;
        j   = $urandom_range(N_ENTRIES - 2);
        mid = (int'(cal_mirror[j]) + int'(cal_mirror[j+1])) >> 1;
        case ($urandom_range(9))
            0:       return cal_mirror[j];
            1:       return cal_mirror[j+1];
            2:       return t_adc'(mid);
            3:       return t_adc'(mid + 1);
            4:       return cal_mirror[j] - 1'b1;
            5:       return cal_mirror[j+1] + 1'b1;
            6:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return t_adc'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= 50)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Drives one transaction and returns at the edge that accepts it. Valid is
    // left high so a back-to-back transaction needs no second assignment.
    task automatic send_item(logic op, logic [IDX_W-1:0] idx, t_adc ev, t_adc av);
        int gap;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_op          <= op;
        in_entry_index <= idx;
        in_entry_value <= ev;
        in_adc_value   <= av;
        @(posedge clk);
        while (o_in_stall !== 1'b0) @(posedge clk);
        if (op == OP_WRITE) begin
            if (idx < N_ENTRIES)
                cal_mirror[idx] = ev;
        end else begin
            expected_lookups.push_back(predict_lookup(av));
        end
    endtask

    task automatic write_entry(int idx, t_adc v);
        send_item(OP_WRITE, IDX_W'(idx), v, t_adc'($urandom));
    endtask

    task automatic convert(t_adc count);
        send_item(OP_CONVERT, IDX_W'($urandom), t_adc'($urandom), count);
    endtask

    // Idle the input, wait out every pending result, then let a trailing
    // table write or scan finish.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base_power(logic signed [BASE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        base_mirror = v;
        cfg_we <= 1'b0;
    endtask

    // mode 0: wide rising, 1: dense rising, 2: scrambled, 3: rising with dents
    task automatic load_table(int mode);
        int level;
        t_adc v;
        level = (mode == 1) ? $urandom_range(60000) : $urandom_range(300);
        for (int i = 0; i < N_ENTRIES; i++) begin
            v = t_adc'((level > 65535) ? 65535 : level);
            if (mode == 2 || (mode == 3 && $urandom_range(6) == 0))
                v = t_adc'($urandom);
            write_entry(i, v);
            // occasional flat step gives duplicate entries
            if ($urandom_range(9) != 0)
                level += (mode == 1) ? $urandom_range(40) : $urandom_range(2180);
        end
        if ($urandom_range(1))
            write_entry(N_ENTRIES, t_adc'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        lookup_result_t want;
        if (rst_n === 1'b1 && o_out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_lookups.pop_front();
                if (o_power_level !== want.power)
                    report_mismatch($sformatf("power_level exp %0d got %0d",
                                              want.power, o_power_level));
                if (o_table_position !== want.pos)
                    report_mismatch($sformatf("table_position exp %0d got %0d",
                                              want.pos, o_table_position));
                if (o_found !== want.found)
                    report_mismatch($sformatf("found exp %0b got %0b",
                                              want.found, o_found));
            end
        end
    end

    // receiver stalls: short bursts mostly, a few long ones
    always @(posedge clk) begin
        if (stall_hold > 0) begin
            out_stall <= 1'b1;
            stall_hold--;
        end else if (!quiet_phase && $urandom_range(4) == 0) begin
            out_stall <= 1'b1;
            stall_hold = pick_burst() - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // Ramp table 0, 2100, 4200 ... 60900, 65535; runs at the reset base_power.
    task automatic test_ramp_lookup();
        for (int i = 0; i < N_ENTRIES - 1; i++)
            write_entry(i, t_adc'(i * 2100));
        write_entry(N_ENTRIES - 1, 16'hFFFF);
        convert(16'd0);        // bottom of range, first-pair rule
        convert(16'd2100);     // equal to entry 1
        convert(16'd2101);     // just above entry 1
        convert(16'd3150);     // midpoint tie picks the lower entry
        convert(16'd3151);
        convert(16'd4200);     // on an entry shared by two pairs
        convert(16'd63217);    // midpoint where the pair sum carries past 16 bits
        convert(16'd63218);
        convert(16'hFFFF);     // top of range
    endtask

    task automatic test_ignored_index();
        write_entry(N_ENTRIES, 16'd0);   // must not touch the table
        convert(16'hFFFF);
        convert(16'd2101);
    endtask

    task automatic test_no_bracket();
        write_entry(N_ENTRIES - 1, 16'd65000);
        convert(16'hFFFF);     // above every pair
        convert(16'd65001);
        convert(16'd65000);
        write_entry(1, 16'hFFFF);        // entry 1 above the rest
        convert(16'd40000);
        convert(16'hFFFF);
        write_entry(1, 16'd2100);
        convert(16'd40000);
    endtask

    task automatic test_base_extremes();
        drain_and_settle();
        write_base_power(-8'sd128);
        convert(16'd65000);
        convert(16'd0);
        drain_and_settle();
        write_base_power(8'sd127);
        convert(16'd65000);
        convert(16'd0);
        convert(16'hFFFF);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < N_PHASES; p++) begin
            drain_and_settle();
            write_base_power(pick_base());
            quiet_phase = ($urandom_range(3) == 0);
            load_table($urandom_range(3));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(9) == 0)
                    write_entry($urandom_range(N_ENTRIES),
                                $urandom_range(1) ? pick_count() : t_adc'($urandom));
                else
                    convert(pick_count());
            end
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        in_valid       <= 1'b0;
        in_op          <= OP_WRITE;
        in_entry_index <= '0;
        in_entry_value <= '0;
        in_adc_value   <= '0;
        out_stall      <= 1'b0;
        base_mirror     = BASE_RESET;
        foreach (cal_mirror[i])
            cal_mirror[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ramp_lookup();
        test_ignored_index();
        test_no_bracket();
        test_base_extremes();
        test_random_phases();

        drain_and_settle();
        if (n_errors == 0)
            $display("adc_to_power_table_lookup_core test passed");
        else
            $display("adc_to_power_table_lookup_core test failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #20_000_000;
        $display("adc_to_power_table_lookup_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/adcpwr_pkg.sv
hw/rtl/adcpwr_ram.sv
hw/rtl/adcpwr_cmp.sv
hw/rtl/adc_to_power_table_lookup_core.sv
tb/tb_adc_to_power_table_lookup_core.sv
